/* sv/sha_pkg.sv */
// shared types, constants and round tables for the sha-256 digest block
`timescale 1ns / 1ps

package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [1:0] {
      BYTE_MSG,
      BYTE_MARK,
      BYTE_ZERO,
      BYTE_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         shift_en;
      byte_sel_type byte_sel;
      logic         count_en;
      logic         load_vars;
      logic         round_en;
      logic         fold;
      logic         restart;
      logic [5:0]   round;
      logic [2:0]   len_idx;
      logic [2:0]   word_idx;
   } cmd_type;

   typedef struct packed {
      logic fill_full;
      logic fill_at_len;
   } sts_type;

   localparam logic [7:0] PAD_MARK  = 8'h80;
   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] FILL_LEN  = 6'd56;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] LEN_LAST  = 3'd7;
   localparam logic [2:0] WORD_LAST = 3'd7;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] dbl;
      dbl = {v, v} >> s;
      return dbl[31:0];
   endfunction

endpackage

/* sv/sha_datapath.sv */
// sha-256 datapath: byte shift window, message schedule, round logic, chaining words
`timescale 1ns / 1ps

module sha_datapath (
   input  logic             clock,
   input  logic             reset,
   input  sha_pkg::cmd_type cmd,
   input  sha_pkg::req_type req_data,
   output sha_pkg::sts_type sts,
   output sha_pkg::rsp_type rsp_data
);

   logic [511:0] window_ff, window_in;
   logic [60:0]  count_ff, count_in;
   logic [5:0]   fill_ff, fill_in;
   logic [31:0]  chain_ff [8];
   logic [31:0]  chain_in [8];
   logic [31:0]  work_ff [8];
   logic [31:0]  work_in [8];

   logic [63:0] bit_len;
   logic [7:0]  len_byte;
   logic [7:0]  shift_byte;
   logic [31:0] w0, w1, w9, w14, sig0, sig1, w_next;
   logic [31:0] big0, big1, choose, major, t1, t2;

   assign bit_len  = {count_ff, 3'b000};
   // length goes out most significant byte first
   assign len_byte = 8'(bit_len >> {~cmd.len_idx, 3'b000});

   always_comb begin
      case (cmd.byte_sel)
         sha_pkg::BYTE_MSG:  shift_byte = req_data.data_byte;
         sha_pkg::BYTE_MARK: shift_byte = sha_pkg::PAD_MARK;
         sha_pkg::BYTE_ZERO: shift_byte = 8'h00;
         sha_pkg::BYTE_LEN:  shift_byte = len_byte;
         default:            shift_byte = 8'h00;
      endcase
   end

   // window holds w[t] .. w[t+15], w[t] in the top word
   assign w0  = window_ff[511:480];
   assign w1  = window_ff[479:448];
   assign w9  = window_ff[223:192];
   assign w14 = window_ff[63:32];
   assign sig0 = sha_pkg::rotr(w1, 5'd7) ^ sha_pkg::rotr(w1, 5'd18) ^ (w1 >> 3);
   assign sig1 = sha_pkg::rotr(w14, 5'd17) ^ sha_pkg::rotr(w14, 5'd19) ^ (w14 >> 10);
   assign w_next = w0 + sig0 + w9 + sig1;

   assign big1 = sha_pkg::rotr(work_ff[4], 5'd6) ^ sha_pkg::rotr(work_ff[4], 5'd11)
               ^ sha_pkg::rotr(work_ff[4], 5'd25);
   assign choose = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign t1 = work_ff[7] + big1 + choose + sha_pkg::ROUND_K[cmd.round] + w0;
   assign big0 = sha_pkg::rotr(work_ff[0], 5'd2) ^ sha_pkg::rotr(work_ff[0], 5'd13)
               ^ sha_pkg::rotr(work_ff[0], 5'd22);
   assign major = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]);
   assign t2 = big0 + major;

   always_comb begin
      window_in = window_ff;
      if (cmd.shift_en) begin
         window_in = {window_ff[503:0], shift_byte};
      end else if (cmd.round_en) begin
         window_in = {window_ff[479:0], w_next};
      end

      count_in = count_ff;
      if (cmd.restart) begin
         count_in = '0;
      end else if (cmd.count_en) begin
         count_in = count_ff + 61'd1;
      end

      fill_in = cmd.shift_en ? fill_ff + 6'd1 : fill_ff;

      for (int i = 0; i < 8; i++) begin
         chain_in[i] = chain_ff[i];
         work_in[i]  = work_ff[i];
         if (cmd.restart) begin
            chain_in[i] = sha_pkg::INIT_HASH[i];
         end else if (cmd.fold) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
         if (cmd.load_vars) begin
            work_in[i] = chain_ff[i];
         end
      end

      if (cmd.round_en) begin
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      for (int i = 0; i < 8; i++) begin
         work_ff[i] <= work_in[i];
      end
      if (reset) begin
         count_ff <= '0;
         fill_ff  <= '0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sha_pkg::INIT_HASH[i];
         end
      end else begin
         count_ff <= count_in;
         fill_ff  <= fill_in;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   assign sts.fill_full   = (fill_ff == sha_pkg::FILL_LAST);
   assign sts.fill_at_len = (fill_ff == sha_pkg::FILL_LEN);

   assign rsp_data.digest_word = chain_ff[cmd.word_idx];
   assign rsp_data.word_index  = cmd.word_idx;
   assign rsp_data.last_word   = (cmd.word_idx == sha_pkg::WORD_LAST);

endmodule

/* sv/sha_ctrl.sv */
// sha-256 controller: byte intake, padding sequence, round count and digest output
`timescale 1ns / 1ps

module sha_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  sha_pkg::req_type req_data,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  sha_pkg::sts_type sts,
   output sha_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_MARK,
      ST_ZERO,
      ST_LEN,
      ST_OUT
   } state_type;

   state_type  state_ff, state_in;
   state_type  resume_ff, resume_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] len_ff, len_in;
   logic [2:0] word_ff, word_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_acc;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign req_acc   = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      resume_in    = resume_ff;
      round_in     = round_ff;
      len_in       = len_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.round    = round_ff;
      cmd.len_idx  = len_ff;
      cmd.word_idx = word_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.has_byte) begin
               cmd.shift_en = 1'b1;
               cmd.byte_sel = sha_pkg::BYTE_MSG;
               cmd.count_en = 1'b1;
               if (sts.fill_full) begin
                  cmd.load_vars = 1'b1;
                  round_in      = '0;
                  state_in      = ST_ROUND;
                  resume_in     = req_data.last ? ST_MARK : ST_IDLE;
               end else if (req_data.last) begin
                  state_in = ST_MARK;
               end
            end else if (req_acc && req_data.last) begin
               state_in = ST_MARK;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == sha_pkg::ROUND_LAST) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = resume_ff;
            if (resume_ff == ST_OUT) begin
               rsp_valid_in = 1'b1;
               word_in      = '0;
            end
         end
         ST_MARK: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = sha_pkg::BYTE_MARK;
            state_in     = ST_ZERO;
            if (sts.fill_full) begin
               cmd.load_vars = 1'b1;
               round_in      = '0;
               state_in      = ST_ROUND;
               resume_in     = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (sts.fill_at_len) begin
               len_in   = '0;
               state_in = ST_LEN;
            end else begin
               cmd.shift_en = 1'b1;
               cmd.byte_sel = sha_pkg::BYTE_ZERO;
               if (sts.fill_full) begin
                  cmd.load_vars = 1'b1;
                  round_in      = '0;
                  state_in      = ST_ROUND;
                  resume_in     = ST_ZERO;
               end
            end
         end
         ST_LEN: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = sha_pkg::BYTE_LEN;
            len_in       = len_ff + 3'd1;
            // eighth length byte completes the final block
            if (len_ff == sha_pkg::LEN_LAST) begin
               cmd.load_vars = 1'b1;
               round_in      = '0;
               state_in      = ST_ROUND;
               resume_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               word_in = word_ff + 3'd1;
               if (word_ff == sha_pkg::WORD_LAST) begin
                  cmd.restart  = 1'b1;
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         resume_ff    <= ST_IDLE;
         round_ff     <= '0;
         len_ff       <= '0;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resume_ff    <= resume_in;
         round_ff     <= round_in;
         len_ff       <= len_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/sha256_message_digest.sv */
// top level of the sha-256 message digest block
// message bytes are taken one per cycle while idle; a full block then runs 64 rounds and a
// fold, and intake waits for them, as the single shared round unit serves every block
// on the last word padding shifts one byte a cycle, pausing during a compression, and ends
// with one or two compressions, then digest words go out one per cycle unless rsp_ready is low
// reset is synchronous: it restores the initial hash values and clears the byte count and
// all control state; the block buffer and round variables are not cleared
`timescale 1ns / 1ps

module sha256_message_digest (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sha_pkg::rsp_type rsp_data
);

   sha_pkg::cmd_type cmd;
   sha_pkg::sts_type sts;

   sha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sha_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

/* sv/sha_checker.sv */
// port-level assertions for the sha-256 digest block, bound to the top level
`timescale 1ns / 1ps

module sha_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sha_pkg::rsp_type rsp_data
);

   // a stalled digest word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled digest word changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("digest word valid right after reset");

   // no new word is taken while the digest drains
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("input ready during digest output");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_word |=>
         rsp_valid && (rsp_data.word_index == 3'($past(rsp_data.word_index) + 3'd1)))
      else $error("digest words out of sequence");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == sha_pkg::WORD_LAST)))
      else $error("last word flag does not match word index");

endmodule

bind sha256_message_digest sha_checker u_sha_checker (.*);

/* verif/tb_sha256_message_digest.sv */
// testbench for the sha-256 message digest block: random messages checked against a digest model
`timescale 1ns / 1ps

module tb_sha256_message_digest;

   localparam logic [31:0] DIGEST_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   class digest_scoreboard;
      logic [31:0]      chain [8];
      logic [7:0]       msg_block [64];
      logic [60:0]      byte_count;
      sha_pkg::rsp_type digest_q [$];
      int               errors;

      function new();
         restart_message();
         errors = 0;
      endfunction

      function void restart_message();
         for (int i = 0; i < 8; i++) chain[i] = DIGEST_IV[i];
         byte_count = '0;
      endfunction

      function logic [31:0] ror32(logic [31:0] v, int s);
         return (v >> s) | (v << (32 - s));
      endfunction

      function void compress_block();
         logic [31:0] sched [16];
         logic [31:0] wv [8];
         logic [31:0] wi, w15, w2, sg0, sg1, t1, t2;
         for (int i = 0; i < 8; i++) wv[i] = chain[i];
         for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
               wi = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
            end else begin
               w15 = sched[(i - 15) % 16];
               w2  = sched[(i - 2) % 16];
               sg0 = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
               sg1 = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
               wi  = sched[i % 16] + sg0 + sched[(i - 7) % 16] + sg1;
            end
            sched[i % 16] = wi;
            t1 = wv[7] + (ror32(wv[4], 6) ^ ror32(wv[4], 11) ^ ror32(wv[4], 25))
                 + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + ROUND_CONST[i] + wi;
            t2 = (ror32(wv[0], 2) ^ ror32(wv[0], 13) ^ ror32(wv[0], 22))
                 + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
            wv[7] = wv[6];
            wv[6] = wv[5];
            wv[5] = wv[4];
            wv[4] = wv[3] + t1;
            wv[3] = wv[2];
            wv[2] = wv[1];
            wv[1] = wv[0];
            wv[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) chain[i] = chain[i] + wv[i];
      endfunction

      function void note_word(sha_pkg::req_type w);
         int               pos;
         logic [63:0]      bit_len;
         sha_pkg::rsp_type d;
         if (w.has_byte) begin
            msg_block[byte_count[5:0]] = w.data_byte;
            byte_count = byte_count + 1'b1;
            if (byte_count[5:0] == 6'd0) compress_block();
         end
         if (!w.last) return;
         pos = int'(byte_count[5:0]);
         msg_block[pos] = 8'h80;
         pos++;
         // no room for the length field: pad out and run an extra block
         if (pos > 56) begin
            while (pos < 64) begin
               msg_block[pos] = 8'h00;
               pos++;
            end
            compress_block();
            pos = 0;
         end
         while (pos < 56) begin
            msg_block[pos] = 8'h00;
            pos++;
         end
         bit_len = {byte_count, 3'b000};
         for (int i = 0; i < 8; i++) msg_block[63 - i] = bit_len[8*i +: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            d.digest_word = chain[i];
            d.word_index  = 3'(i);
            d.last_word   = (i == 7);
            digest_q.push_back(d);
         end
         restart_message();
      endfunction

      function void check_word(sha_pkg::rsp_type r);
         sha_pkg::rsp_type want;
         if (digest_q.size() == 0) begin
            $error("unexpected digest word %h index %0d", r.digest_word, r.word_index);
            errors++;
            return;
         end
         want = digest_q.pop_front();
         if (r.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, got %h", want.digest_word, r.digest_word);
            errors++;
         end
         if (r.word_index !== want.word_index) begin
            $error("word_index: expected %0d, got %0d", want.word_index, r.word_index);
            errors++;
         end
         if (r.last_word !== want.last_word) begin
            $error("last_word: expected %0d, got %0d", want.last_word, r.last_word);
            errors++;
         end
      endfunction

      function int pending();
         return digest_q.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sha_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sha_pkg::rsp_type rsp_data;

   digest_scoreboard sb = new();
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               item_count = 0;

   sha256_message_digest dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_data);
   end

   // entered and left at a falling edge
   task automatic put_word(input sha_pkg::req_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = w;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(w);
      @(negedge clock);
   endtask

   task automatic put_message(input int len, input bit byte_on_last);
      sha_pkg::req_type w;
      int               r;
      for (int n = 0; n < len; n++) begin
         // an ignored word now and then
         if ($urandom_range(0, 19) == 0) begin
            w.data_byte = 8'($urandom_range(0, 255));
            w.has_byte  = 1'b0;
            w.last      = 1'b0;
            put_word(w);
         end
         r = $urandom_range(0, 9);
         w.data_byte = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom_range(0, 255));
         w.has_byte  = 1'b1;
         w.last      = byte_on_last && (n == len - 1);
         put_word(w);
         item_count++;
      end
      if (len == 0 || !byte_on_last) begin
         w.data_byte = 8'($urandom_range(0, 255));
         w.has_byte  = 1'b0;
         w.last      = 1'b1;
         put_word(w);
         item_count++;
      end
   endtask

   initial begin
      #(8_000_000);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int len;
      int r;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty message, preceded by an ignored word
      put_word('{data_byte: 8'hff, has_byte: 1'b0, last: 1'b0});
      put_word('{data_byte: 8'h00, has_byte: 1'b0, last: 1'b1});
      // "abc" with the final byte on the last word
      put_word('{data_byte: 8'h61, has_byte: 1'b1, last: 1'b0});
      put_word('{data_byte: 8'h62, has_byte: 1'b1, last: 1'b0});
      put_word('{data_byte: 8'h63, has_byte: 1'b1, last: 1'b1});
      // byte extremes, then a last word without a byte
      put_word('{data_byte: 8'h00, has_byte: 1'b1, last: 1'b0});
      put_word('{data_byte: 8'hff, has_byte: 1'b1, last: 1'b0});
      put_word('{data_byte: 8'h00, has_byte: 1'b0, last: 1'b0});
      put_word('{data_byte: 8'ha5, has_byte: 1'b0, last: 1'b1});
      // one-byte message, then empty messages back to back
      put_word('{data_byte: 8'hff, has_byte: 1'b1, last: 1'b1});
      put_word('{data_byte: 8'hff, has_byte: 1'b0, last: 1'b1});
      put_word('{data_byte: 8'h5a, has_byte: 1'b0, last: 1'b1});
      item_count = 12;

      while (item_count < 450) begin
         if (item_count < 110) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end else if (item_count < 220) begin
            send_idle_pct = 58;
            recv_stall_pct = 0;
         end else if (item_count < 330) begin
            send_idle_pct = 0;
            recv_stall_pct = 58;
         end else begin
            send_idle_pct = 22;
            recv_stall_pct = 22;
         end
         r = $urandom_range(0, 9);
         if (r < 5) begin
            len = $urandom_range(0, 20);
         end else if (r < 8) begin
            // lengths around the padding and block boundaries
            case ($urandom_range(0, 9))
               0: len = 55;
               1: len = 56;
               2: len = 57;
               3: len = 63;
               4: len = 64;
               5: len = 65;
               6: len = 119;
               7: len = 120;
               8: len = 127;
               default: len = 128;
            endcase
         end else begin
            len = $urandom_range(21, 140);
         end
         if (len > 450 - item_count) len = 450 - item_count;
         put_message(len, $urandom_range(0, 1));
      end
      req_valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
